/* src/rmvt_pkg.sv */
// rmvt_pkg: shared types and constants for the running mean/variance table
// no dependencies
package rmvt_pkg;
  localparam int FactorW = 3;
  localparam int EntryW = 8;
  localparam int RewardW = 32;
  localparam int CountW = 24;
  localparam int MeanW = 32;
  localparam int M2W = 63;
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};
  localparam logic [M2W-1:0] M2Max = {M2W{1'b1}};

  typedef struct packed {
    logic [FactorW-1:0] factor;
    logic [EntryW-1:0] entry;
    logic signed [RewardW-1:0] reward;
  } in_item_t;

  typedef struct packed {
    logic [FactorW-1:0] out_factor;
    logic [EntryW-1:0] out_entry;
    logic [CountW-1:0] count;
    logic signed [MeanW-1:0] mean;
    logic [M2W-1:0] m2;
  } out_item_t;

  // classified job handed from front to back
  typedef struct packed {
    logic in_range;
    logic [FactorW-1:0] factor;
    logic [EntryW-1:0] entry;
    logic signed [RewardW-1:0] reward;
  } job_t;
endpackage

/* src/rmvt_if.sv */
// rmvt_if: valid/ready channel interfaces for input and result beats
// depends on rmvt_pkg
interface rmvt_in_if import rmvt_pkg::*; ();
  logic valid;
  logic ready;
  logic [FactorW-1:0] factor;
  logic [EntryW-1:0] entry;
  logic signed [RewardW-1:0] reward;
  modport source (output valid, factor, entry, reward, input ready);
  modport sink (input valid, factor, entry, reward, output ready);
endinterface

interface rmvt_out_if import rmvt_pkg::*; ();
  logic valid;
  logic ready;
  logic [FactorW-1:0] out_factor;
  logic [EntryW-1:0] out_entry;
  logic [CountW-1:0] count;
  logic signed [MeanW-1:0] mean;
  logic [M2W-1:0] m2;
  modport source (output valid, out_factor, out_entry, count, mean, m2, input ready);
  modport sink (input valid, out_factor, out_entry, count, mean, m2, output ready);
endinterface

/* src/rmvt_ram.sv */
// rmvt_ram: generic single-port-write, single-port-read ram, registered read
// no dependencies
module rmvt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* src/rmvt_front.sv */
// rmvt_front: accepts input beats, range checks them, queues jobs
// depends on rmvt_pkg, rmvt_if
module rmvt_front import rmvt_pkg::*; #(
  parameter int FACTORS = 8,
  parameter int ENTRIES_PER_FACTOR = 256,
  parameter int QDepth = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic block,
  rmvt_in_if.sink in_ch,
  output logic job_valid,
  input  logic job_ready,
  output job_t job
);
  localparam int PW = $clog2(QDepth);
  job_t q [QDepth];
  logic [PW-1:0] wp, rp;
  logic [PW:0] fill;
  logic push, pop;
  job_t nj;

  assign in_ch.ready = !block && (fill != (PW+1)'(QDepth));
  assign push = in_ch.valid && in_ch.ready;
  assign pop = job_valid && job_ready;
  assign job_valid = fill != '0;
  assign job = q[rp];

  always_comb begin
    nj.factor = in_ch.factor;
    nj.entry = in_ch.entry;
    nj.reward = in_ch.reward;
    nj.in_range = (32'(in_ch.factor) < FACTORS) && (32'(in_ch.entry) < ENTRIES_PER_FACTOR);
  end

  always_ff @(posedge clk) begin
    if (push) q[wp] <= nj;
    if (rst) begin
      wp <= '0;
      rp <= '0;
      fill <= '0;
    end else begin
      if (push) wp <= (32'(wp) == QDepth-1) ? '0 : wp + 1'b1;
      if (pop) rp <= (32'(rp) == QDepth-1) ? '0 : rp + 1'b1;
      fill <= fill + (PW+1)'(push) - (PW+1)'(pop);
    end
  end
endmodule

/* src/rmvt_div.sv */
// rmvt_div: restoring divider, one quotient bit per cycle, magnitudes
// depends on rmvt_pkg
module rmvt_div import rmvt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [32:0] dividend,
  input  logic [CountW-1:0] divisor,
  output logic done,
  output logic [32:0] quotient
);
  logic [5:0] cnt;
  logic busy;
  logic [32:0] qr;
  logic [CountW:0] rem;
  logic [CountW:0] trial;

  assign trial = {rem[CountW-1:0], qr[32]} - {1'b0, divisor};
  assign quotient = qr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 6'd33;
        qr <= dividend;
        rem <= '0;
      end else if (busy) begin
        if (!trial[CountW]) begin
          rem <= trial;
          qr <= {qr[31:0], 1'b1};
        end else begin
          rem <= {rem[CountW-1:0], qr[32]};
          qr <= {qr[31:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

/* src/rmvt_back.sv */
// rmvt_back: welford update sequencer over the three tables
// depends on rmvt_pkg, rmvt_ram, rmvt_div
module rmvt_back import rmvt_pkg::*; #(
  parameter int FACTORS = 8,
  parameter int ENTRIES_PER_FACTOR = 256
) (
  input  logic clk,
  input  logic rst,
  output logic clearing,
  input  logic job_valid,
  output logic job_ready,
  input  job_t job,
  rmvt_out_if.source out_ch
);
  localparam int Depth = FACTORS * ENTRIES_PER_FACTOR;
  localparam int AW = $clog2(Depth);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_READ, S_DATA, S_DIVGO, S_DIV, S_RESID, S_MULLO, S_MULHI, S_ACC, S_OUT
  } state_t;
  state_t state;

  logic [AW:0] clr;
  job_t cur;
  logic [AW-1:0] addr, raddr, waddr;
  logic we;
  logic [CountW-1:0] c_rd, c_new;
  logic [MeanW-1:0] mu_rd;
  logic [M2W-1:0] m2_rd;
  logic [CountW-1:0] wc;
  logic [MeanW-1:0] wmu;
  logic [M2W-1:0] wm2;
  logic [M2W-1:0] wm2_q;
  logic signed [32:0] delta, resid;
  logic [32:0] dmag;
  logic div_start, div_done;
  logic [32:0] q;
  logic signed [MeanW-1:0] mean_old, newmean;
  logic [M2W-1:0] m2_old;
  logic [31:0] am, bm;
  logic [63:0] plo, phi, prod;
  logic neg;
  logic [64:0] sum;
  logic obusy;
  out_item_t ob;

  assign addr = AW'(32'(cur.factor) * ENTRIES_PER_FACTOR + 32'(cur.entry));
  assign raddr = addr;
  assign clearing = (state == S_CLEAR);
  assign job_ready = (state == S_IDLE);

  rmvt_ram #(.Width(CountW), .Depth(Depth)) u_cnt (.clk, .we, .waddr, .wdata(wc),
    .raddr, .rdata(c_rd));
  rmvt_ram #(.Width(MeanW), .Depth(Depth)) u_mean (.clk, .we, .waddr, .wdata(wmu),
    .raddr, .rdata(mu_rd));
  rmvt_ram #(.Width(M2W), .Depth(Depth)) u_m2 (.clk, .we, .waddr, .wdata(wm2),
    .raddr, .rdata(m2_rd));
  rmvt_div u_div (.clk, .rst, .start(div_start), .dividend(dmag), .divisor(c_new),
    .done(div_done), .quotient(q));

  assign dmag = delta[32] ? 33'(-delta) : 33'(delta);
  // delta and the new count are registered in S_DATA, so the divider is started in S_DIVGO, the state after
  assign div_start = (state == S_DIVGO);
  assign sum = {2'b0, m2_old} + {1'b0, prod};

  always_comb begin
    we = 1'b0;
    waddr = addr;
    wc = c_new;
    wmu = newmean;
    wm2 = m2_old;
    if (state == S_CLEAR) begin
      we = 1'b1;
      waddr = clr[AW-1:0];
      wc = '0;
      wmu = '0;
      wm2 = '0;
    end else if (state == S_ACC) begin
      we = 1'b1;
      if (neg) wm2 = (prod >= {1'b0, m2_old}) ? '0 : m2_old - prod[M2W-1:0];
      else wm2 = (sum > {2'b0, M2Max}) ? M2Max : sum[M2W-1:0];
    end
  end

  assign out_ch.valid = obusy;
  assign out_ch.out_factor = ob.out_factor;
  assign out_ch.out_entry = ob.out_entry;
  assign out_ch.count = ob.count;
  assign out_ch.mean = ob.mean;
  assign out_ch.m2 = ob.m2;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      obusy <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) obusy <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (32'(clr) == Depth-1) state <= S_IDLE;
        end
        S_IDLE: if (job_valid) begin
          cur <= job;
          state <= job.in_range ? S_READ : S_OUT;
        end
        S_READ: state <= S_DATA;
        S_DATA: begin
          c_new <= (c_rd == CountMax) ? c_rd : c_rd + 1'b1;
          mean_old <= mu_rd;
          m2_old <= m2_rd;
          delta <= 33'(cur.reward) - 33'(signed'(mu_rd));
          state <= S_DIVGO;
        end
        S_DIVGO: state <= S_DIV;
        S_DIV: if (div_done) begin
          newmean <= MeanW'(33'(mean_old) + (delta[32] ? -q : q));
          state <= S_RESID;
        end
        S_RESID: begin
          resid <= 33'(cur.reward) - 33'(newmean);
          state <= S_MULLO;
        end
        S_MULLO: begin
          // 33x33 magnitude product split into a 32x32 low product and bit-32 correction terms
          am <= dmag[31:0];
          bm <= resid[32] ? 32'(-resid) : 32'(resid);
          neg <= (delta[32] != resid[32]) && delta != '0 && resid != '0;
          state <= S_MULHI;
        end
        S_MULHI: begin
          plo <= am * bm;
          phi <= (dmag[32] ? 64'(bm) << 32 : '0)
               + ((resid[32] && 32'(-resid) == 32'd0 && resid != '0) ? 64'(am) << 32 : '0);
          state <= S_ACC;
        end
        S_ACC: begin
          wm2_q <= wm2;
          state <= S_OUT;
        end
        S_OUT: if (!obusy) begin
          obusy <= 1'b1;
          ob.out_factor <= cur.factor;
          ob.out_entry <= cur.entry;
          if (cur.in_range) begin
            ob.count <= c_new;
            ob.mean <= newmean;
            ob.m2 <= wm2_q;
          end else begin
            ob.count <= '0;
            ob.mean <= '0;
            ob.m2 <= '0;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign prod = plo + phi;
endmodule

/* src/running_mean_variance_table.sv */
// channel   dir  fields
// in_ch     in   factor, entry, reward
// out_ch    out  out_factor, out_entry, count, mean, m2
// an item with an idle back end goes from input beat to result beat through the
// table read, a 33-step divider started in the cycle after the read data, residual,
// product and write-back steps; items are worked one at a time
// after reset a clearing pass writes zeros over FACTORS*ENTRIES_PER_FACTOR
// entries, one per cycle (2048 entries by default), and no input beat is taken during it
// a two-deep queue lets the front accept beats while the back end or output stalls
// depends on rmvt_pkg, rmvt_if, rmvt_front, rmvt_back
module running_mean_variance_table import rmvt_pkg::*; #(
  parameter int FACTORS = 8,
  parameter int ENTRIES_PER_FACTOR = 256
) (
  input logic clk,
  input logic rst,
  rmvt_in_if.sink in_ch,
  rmvt_out_if.source out_ch
);
  logic job_valid, job_ready, clearing;
  job_t job;

  rmvt_front #(.FACTORS(FACTORS), .ENTRIES_PER_FACTOR(ENTRIES_PER_FACTOR)) u_front (
    .clk, .rst, .block(clearing), .in_ch, .job_valid, .job_ready, .job);
  rmvt_back #(.FACTORS(FACTORS), .ENTRIES_PER_FACTOR(ENTRIES_PER_FACTOR)) u_back (
    .clk, .rst, .clearing, .job_valid, .job_ready, .job, .out_ch);

`ifndef ASSERT_OFF
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !in_ch.ready) else $error("input taken during clear");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.m2))
    else $error("result dropped");
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.count == '0 |-> out_ch.m2 == '0 && out_ch.mean == '0)
    else $error("empty entry with data");
`endif
endmodule
